// ===== hdl/dbdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdd_pkg
// Shared widths and fixed-point constants of the box delta decoder.
// ----------------------------------------------------------------------------
package dbdd_pkg;

	// Field widths
	localparam int COORD_W = 16;
	localparam int DELTA_W = 16;
	localparam int DIM_W   = 13;

	// Pipeline depth from accepted input transaction to output register
	localparam int DEPTH = 9;

	// Configuration register indexes (byte address bit 2)
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// log2(e) in Q.16
	localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

	// 2^f polynomial coefficients, Q.16
	localparam logic [15:0] EXP_C1 = 16'd45559;
	localparam logic [14:0] EXP_C2 = 15'd14823;
	localparam logic [12:0] EXP_C3 = 13'd5154;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [DIM_W-1:0]          dim_t;

endpackage

// ===== hdl/dbdd_axis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdd_axis
// Nine-stage decode of one axis: size and centre, centre shift, exp(delta)
// via 2^n * 2^f polynomial, corner forming, clip and round to Q12.4.
// ----------------------------------------------------------------------------
module dbdd_axis (
	input  logic            clk,
	input  logic            en,
	input  dbdd_pkg::coord_t near,
	input  dbdd_pkg::coord_t far,
	input  dbdd_pkg::delta_t d,
	input  dbdd_pkg::delta_t e,
	input  dbdd_pkg::dim_t   dim,
	output dbdd_pkg::coord_t lo,
	output dbdd_pkg::coord_t hi
);

	// Stage 1: signed size in Q.4
	logic signed [17:0] s_c;
	logic signed [17:0] s_s1;
	dbdd_pkg::coord_t   near_s1;
	dbdd_pkg::delta_t   d_s1;
	dbdd_pkg::delta_t   e_s1;

	assign s_c = $signed({2'b00, far}) - $signed({2'b00, near}) + 18'sd16;

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1    <= s_c;
			near_s1 <= near;
			d_s1    <= d;
			e_s1    <= e;
		end
	end

	// Stage 2: size times shift, log-scale times log2(e)
	logic signed [33:0] sd_c;
	logic signed [33:0] ey_c;
	logic signed [33:0] sd_s2;
	logic signed [33:0] ey_s2;
	logic signed [17:0] s_s2;
	dbdd_pkg::coord_t   near_s2;

	assign sd_c = s_s1 * d_s1;
	assign ey_c = e_s1 * dbdd_pkg::LOG2E_Q16;

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2   <= sd_c;
			ey_s2   <= ey_c;
			s_s2    <= s_s1;
			near_s2 <= near_s1;
		end
	end

	// Stage 3: moved centre, split exponent into integer and fraction
	logic signed [35:0] p_c;
	logic signed [33:0] yt_c;
	logic signed [21:0] y_c;
	logic [28:0]        rp_c;
	logic signed [35:0] p_s3;
	logic signed [5:0]  n_s3;
	logic [15:0]        f_s3;
	logic [28:0]        rp_s3;
	logic signed [17:0] s_s3;

	assign p_c  = $signed({8'b0, near_s2, 12'b0}) + (36'(s_s2) <<< 11) + 36'(sd_s2);
	assign yt_c = ey_s2 + 34'sd2048;
	assign y_c  = yt_c[33:12];
	assign rp_c = 29'(y_c[15:0]) * 29'(dbdd_pkg::EXP_C3);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s3  <= p_c;
			n_s3  <= y_c[21:16];
			f_s3  <= y_c[15:0];
			rp_s3 <= rp_c;
			s_s3  <= s_s2;
		end
	end

	// Stage 4: first polynomial step
	logic [14:0]        r_c;
	logic [30:0]        rf_c;
	logic [30:0]        rf_s4;
	logic [15:0]        f_s4;
	logic signed [5:0]  n_s4;
	logic signed [35:0] p_s4;
	logic signed [17:0] s_s4;

	assign r_c  = dbdd_pkg::EXP_C2 + 15'(rp_s3[28:16]);
	assign rf_c = 31'(r_c) * 31'(f_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			rf_s4 <= rf_c;
			f_s4  <= f_s3;
			n_s4  <= n_s3;
			p_s4  <= p_s3;
			s_s4  <= s_s3;
		end
	end

	// Stage 5: second polynomial step
	logic [15:0]        q_c;
	logic [31:0]        qf_c;
	logic [31:0]        qf_s5;
	logic signed [5:0]  n_s5;
	logic signed [35:0] p_s5;
	logic signed [17:0] s_s5;

	assign q_c  = dbdd_pkg::EXP_C1 + 16'(rf_s4[30:16]);
	assign qf_c = 32'(q_c) * 32'(f_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			qf_s5 <= qf_c;
			n_s5  <= n_s4;
			p_s5  <= p_s4;
			s_s5  <= s_s4;
		end
	end

	// Stage 6: 2^f mantissa times size magnitude
	logic [16:0]        m_c;
	logic [16:0]        sabs_c;
	logic [33:0]        mag_c;
	logic [33:0]        mag_s6;
	logic               neg_s6;
	logic signed [5:0]  n_s6;
	logic signed [35:0] p_s6;

	assign m_c    = 17'h10000 + 17'(qf_s5[31:16]);
	assign sabs_c = s_s5[17] ? 17'(-s_s5) : 17'(s_s5);
	assign mag_c  = 34'(sabs_c) * 34'(m_c);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s6 <= mag_c;
			neg_s6 <= s_s5[17];
			n_s6   <= n_s5;
			p_s6   <= p_s5;
		end
	end

	// Stage 7: scale by 2^(n-4), rounding half up on right shifts
	logic signed [6:0]  sh_c;
	logic [4:0]         k_c;
	logic [34:0]        rnd_c;
	logic [40:0]        zmag_c;
	logic signed [41:0] z_c;
	logic signed [41:0] z_s7;
	logic signed [35:0] p_s7;

	assign sh_c  = 7'(n_s6) - 7'sd4;
	assign k_c   = 5'(-sh_c);
	assign rnd_c = 35'(1) << (k_c - 5'd1);

	always_comb begin
		if (!sh_c[6]) begin
			zmag_c = 41'(mag_s6) << sh_c[2:0];
		end else begin
			zmag_c = 41'((35'(mag_s6) + rnd_c) >> k_c);
		end
		z_c = neg_s6 ? -$signed({1'b0, zmag_c}) : $signed({1'b0, zmag_c});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s7 <= z_c;
			p_s7 <= p_s6;
		end
	end

	// Stage 8: corners in Q.17
	logic signed [43:0] twop_c;
	logic signed [43:0] lo_s8;
	logic signed [43:0] hi_s8;

	assign twop_c = 44'(p_s7) <<< 1;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s8 <= twop_c - 44'(z_s7);
			hi_s8 <= twop_c + 44'(z_s7);
		end
	end

	// Stage 9: clip to image, round to Q12.4, saturate
	dbdd_pkg::dim_t bound_c;
	logic [29:0]    lim_c;

	assign bound_c = (dim == '0) ? '0 : dim - 13'd1;
	assign lim_c   = {bound_c, 17'b0};

	function automatic dbdd_pkg::coord_t clip_round(logic signed [43:0] v, logic [29:0] lim);
		logic [29:0] vc;
		logic [30:0] o;
		if (v[43]) begin
			vc = '0;
		end else if (v > $signed({14'b0, lim})) begin
			vc = lim;
		end else begin
			vc = v[29:0];
		end
		o = (31'(vc) + 31'd4096) >> 13;
		return (o > 31'd65535) ? 16'hFFFF : o[15:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			lo <= clip_round(lo_s8, lim_c);
			hi <= clip_round(hi_s8, lim_c);
		end
	end

endmodule

// ===== hdl/detection_box_delta_decode_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_delta_decode_top
// Bounding-box regression decoder: proposal corners plus class deltas in,
// decoded corners clipped to the image out, score and tags passed along.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one proposal box, four deltas,
//   the class score and two tags per transaction. Output channel
//   (out_valid/out_stall) returns exactly one decoded box per input, in order.
//   Throughput is one transaction per cycle, as each of the nine registered
//   stages of the axis pipelines takes a new transaction whenever the
//   pipeline advances.
//   The pipeline advances as a whole: while a result waits at the output and
//   out_stall is high, every stage holds and in_stall is raised; nothing is
//   lost or repeated. Bubbles travel with their valid bit.
//   The APB port sets image_width (0x0) and image_height (0x4), both reset to
//   1024; write them only while no transaction is in flight.
//   Reset clears all valid bits and restores the image size registers.
// ----------------------------------------------------------------------------
module detection_box_delta_decode_top (
	input  logic                    clk,
	input  logic                    arst_n,
	// APB configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// Input channel
	input  logic                    in_valid,
	output logic                    in_stall,
	input  dbdd_pkg::coord_t        box_left,
	input  dbdd_pkg::coord_t        box_top,
	input  dbdd_pkg::coord_t        box_right,
	input  dbdd_pkg::coord_t        box_bottom,
	input  dbdd_pkg::delta_t        delta_x,
	input  dbdd_pkg::delta_t        delta_y,
	input  dbdd_pkg::delta_t        delta_w,
	input  dbdd_pkg::delta_t        delta_h,
	input  logic [15:0]             class_score,
	input  logic [6:0]              class_index,
	input  logic [8:0]              roi_index,
	// Output channel
	output logic                    out_valid,
	input  logic                    out_stall,
	output dbdd_pkg::coord_t        out_left,
	output dbdd_pkg::coord_t        out_top,
	output dbdd_pkg::coord_t        out_right,
	output dbdd_pkg::coord_t        out_bottom,
	output logic [15:0]             out_score,
	output logic [6:0]              out_class,
	output logic [8:0]              out_roi
);

	localparam dbdd_pkg::dim_t DIM_RESET = 13'd1024;

	typedef struct packed {
		logic [15:0] score;
		logic [6:0]  cls;
		logic [8:0]  roi;
	} tag_t;

	// Configuration registers
	dbdd_pkg::dim_t width_q;
	dbdd_pkg::dim_t height_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				dbdd_pkg::REG_IMAGE_WIDTH:  width_q  <= pwdata[12:0];
				dbdd_pkg::REG_IMAGE_HEIGHT: height_q <= pwdata[12:0];
				default:                    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dbdd_pkg::REG_IMAGE_WIDTH:  prdata = {19'b0, width_q};
			dbdd_pkg::REG_IMAGE_HEIGHT: prdata = {19'b0, height_q};
			default:                    prdata = '0;
		endcase
	end

	// Global pipeline advance: hold everything while the output is stalled
	logic en;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// Valid and tag shift line alongside the axis pipelines
	logic vld_q [dbdd_pkg::DEPTH];
	tag_t tag_q [dbdd_pkg::DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dbdd_pkg::DEPTH; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < dbdd_pkg::DEPTH; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q[0] <= '{score: class_score, cls: class_index, roi: roi_index};
			for (int i = 1; i < dbdd_pkg::DEPTH; i++) begin
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	assign out_valid = vld_q[dbdd_pkg::DEPTH-1];
	assign out_score = tag_q[dbdd_pkg::DEPTH-1].score;
	assign out_class = tag_q[dbdd_pkg::DEPTH-1].cls;
	assign out_roi   = tag_q[dbdd_pkg::DEPTH-1].roi;

	// Horizontal axis
	dbdd_axis u_axis_x (
		.clk  (clk),
		.en   (en),
		.near (box_left),
		.far  (box_right),
		.d    (delta_x),
		.e    (delta_w),
		.dim  (width_q),
		.lo   (out_left),
		.hi   (out_right)
	);

	// Vertical axis
	dbdd_axis u_axis_y (
		.clk  (clk),
		.en   (en),
		.near (box_top),
		.far  (box_bottom),
		.d    (delta_y),
		.e    (delta_h),
		.dim  (height_q),
		.lo   (out_top),
		.hi   (out_bottom)
	);

endmodule
